// File: sv/ccc_pkg.sv
package ccc_pkg;

    // fixed geometry of the arithmetic
    localparam int FRAC_BITS   = 30;
    localparam int SQRT_IN_W   = 64;
    localparam int SQRT_OUT_W  = 32;
    localparam int SQRT_STAGES = 32;
    localparam int DIST_W      = 32;
    localparam int SPEC_W      = 31;
    localparam logic [SPEC_W-1:0] SPEC_RESET = 31'd1311;

    // cycles from an accepted start to the result strobe
    localparam int LATENCY = 8 + (FRAC_BITS + 1) + 5 + SQRT_STAGES + 1 + (FRAC_BITS + 1) + 8;

    localparam logic signed [65:0] SYM_MAX  = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN  = -66'sd2147483648;
    localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;

    typedef struct packed {
        logic [63:0] capsule_end_one;
        logic [63:0] capsule_end_two;
        logic [30:0] capsule_radius;
        logic [63:0] circle_center;
        logic [30:0] circle_radius;
        logic [63:0] pose_a_position;
        logic [63:0] pose_a_rotation;
        logic [63:0] pose_b_position;
        logic [63:0] pose_b_rotation;
    } t_item;

    typedef struct packed {
        logic               contact;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] anchor_a_x;
        logic signed [31:0] anchor_a_y;
        logic signed [31:0] anchor_b_x;
        logic signed [31:0] anchor_b_y;
        logic signed [31:0] world_point_x;
        logic signed [31:0] world_point_y;
        logic signed [31:0] separation;
    } t_result;

    // which point of the core segment is nearest
    typedef enum logic [1:0] {
        SEG_P1,
        SEG_P2,
        SEG_MID
    } t_seg_sel;

    // per-item context carried down the pipeline
    typedef struct packed {
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic        [30:0] ra;
        logic        [30:0] rb;
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] pbx;
        logic signed [31:0] pby;
        logic signed [31:0] ca;
        logic signed [31:0] sa;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [63:0] m0;
        logic signed [63:0] m1;
        logic signed [63:0] m2;
        logic signed [63:0] m3;
        logic signed [63:0] m4;
        logic signed [63:0] m5;
        logic signed [63:0] m6;
        logic signed [63:0] m7;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic        [63:0] ee;
        logic signed [64:0] s1;
        logic signed [64:0] s2;
        t_seg_sel           sel;
        logic        [29:0] t;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic        [63:0] sq;
        logic        [31:0] dlen;
        logic        [30:0] mvx;
        logic        [30:0] mvy;
        logic               negx;
        logic               negy;
        logic signed [33:0] sep;
        logic               hit;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [35:0] rax;
        logic signed [35:0] ray;
        logic signed [35:0] rbx;
        logic signed [35:0] rby;
        logic signed [31:0] nwx;
        logic signed [31:0] nwy;
        logic signed [36:0] cax;
        logic signed [36:0] cay;
        logic signed [36:0] cbx;
        logic signed [36:0] cby;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] anx;
        logic signed [31:0] anc_y;
    } t_ctx;

    // clamp to the symmetric 32-bit range
    function automatic logic signed [31:0] sym_sat(input logic signed [65:0] x);
        if (x > SYM_MAX) begin
            return 32'sd2147483647;
        end else if (x < -SYM_MAX) begin
            return -32'sd2147483647;
        end
        return x[31:0];
    endfunction

    // clamp to the full signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > SYM_MAX) begin
            return 32'sd2147483647;
        end else if (x < S32_MIN) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // drop 30 fraction bits, rounding half up
    function automatic logic signed [35:0] round30(input logic signed [65:0] x);
        logic signed [65:0] l_sum;
        l_sum = x + HALF_Q30;
        return 36'(l_sum >>> 30);
    endfunction

endpackage

// File: sv/capsule_circle_contact_top.sv
// throughput: one pair per cycle, busy stays low outside reset
// the depth comes from the 31-stage fraction divider, the 32-stage square
// root and the 31-stage normal divider, each one bit per stage
// reset (synchronous, active low) empties the pipeline and loads the
// speculative distance with its default; the receiver cannot stall
module capsule_circle_contact_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ccc_pkg::t_item                i_item,
    output logic                          o_result_strobe,
    output ccc_pkg::t_result              o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ccc_pkg::SPEC_W-1:0]    i_cfg_data
);
    import ccc_pkg::*;

    localparam int CTX_W = $bits(t_ctx);

    logic [SPEC_W-1:0] r_spec;
    logic              w_accept;

    t_ctx r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8;
    t_ctx n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
    t_ctx r_s9, r_s10, r_s11, r_s12, r_s13, r_s14;
    t_ctx n_s9, n_s10, n_s11, n_s12, n_s13, n_s14;
    t_ctx r_s15, r_s16, r_s17, r_s18, r_s19, r_s20, r_s21;
    t_ctx n_s15, n_s16, n_s17, n_s18, n_s19, n_s20, n_s21;
    t_result r_out, n_out;

    logic [7:0] r_vld_a;
    logic [4:0] r_vld_b;
    logic       r_vld_c;
    logic [7:0] r_vld_d;

    logic                      w_dt_vld;
    logic [0:0][FRAC_BITS:0]   w_dt_quo;
    logic [CTX_W-1:0]          w_dt_side;
    logic                      w_sq_vld;
    logic [SQRT_OUT_W-1:0]     w_sq_root;
    logic [CTX_W-1:0]          w_sq_side;
    logic                      w_dn_vld;
    logic [1:0][FRAC_BITS:0]   w_dn_quo;
    logic [CTX_W-1:0]          w_dn_side;

    // handshakes
    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = start && !busy;

    // speculative distance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spec <= SPEC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_spec <= i_cfg_data;
        end
    end

    // s1: unpack, segment edge, circle center rotation products
    always_comb begin
        logic signed [31:0] l_x, l_y, l_cb, l_sb;
        n_s1     = '0;
        n_s1.p1x = $signed(i_item.capsule_end_one[63:32]);
        n_s1.p1y = $signed(i_item.capsule_end_one[31:0]);
        n_s1.p2x = $signed(i_item.capsule_end_two[63:32]);
        n_s1.p2y = $signed(i_item.capsule_end_two[31:0]);
        n_s1.ra  = i_item.capsule_radius;
        n_s1.rb  = i_item.circle_radius;
        n_s1.pax = $signed(i_item.pose_a_position[63:32]);
        n_s1.pay = $signed(i_item.pose_a_position[31:0]);
        n_s1.pbx = $signed(i_item.pose_b_position[63:32]);
        n_s1.pby = $signed(i_item.pose_b_position[31:0]);
        n_s1.ca  = $signed(i_item.pose_a_rotation[63:32]);
        n_s1.sa  = $signed(i_item.pose_a_rotation[31:0]);
        l_cb     = $signed(i_item.pose_b_rotation[63:32]);
        l_sb     = $signed(i_item.pose_b_rotation[31:0]);
        l_x      = sym_sat(66'($signed(i_item.circle_center[63:32])));
        l_y      = sym_sat(66'($signed(i_item.circle_center[31:0])));
        n_s1.ex  = sym_sat(66'(n_s1.p2x - n_s1.p1x));
        n_s1.ey  = sym_sat(66'(n_s1.p2y - n_s1.p1y));
        n_s1.m0  = 64'(l_cb * l_x);
        n_s1.m1  = 64'(l_sb * l_y);
        n_s1.m2  = 64'(l_sb * l_x);
        n_s1.m3  = 64'(l_cb * l_y);
    end

    // s2: circle center in world frame
    always_comb begin
        n_s2    = r_s1;
        n_s2.wx = sat32(66'(round30(66'(r_s1.m0 - r_s1.m1)) + r_s1.pbx));
        n_s2.wy = sat32(66'(round30(66'(r_s1.m2 + r_s1.m3)) + r_s1.pby));
    end

    // s3: offset from capsule body
    always_comb begin
        n_s3    = r_s2;
        n_s3.dx = sym_sat(66'(r_s2.wx - r_s2.pax));
        n_s3.dy = sym_sat(66'(r_s2.wy - r_s2.pay));
    end

    // s4: inverse rotation products and edge length products
    always_comb begin
        n_s4    = r_s3;
        n_s4.m0 = 64'(r_s3.ca * r_s3.dx);
        n_s4.m1 = 64'(r_s3.sa * r_s3.dy);
        n_s4.m2 = 64'(r_s3.sa * r_s3.dx);
        n_s4.m3 = 64'(r_s3.ca * r_s3.dy);
        n_s4.m4 = 64'(r_s3.ex * r_s3.ex);
        n_s4.m5 = 64'(r_s3.ey * r_s3.ey);
    end

    // s5: circle center in capsule frame
    always_comb begin
        n_s5    = r_s4;
        n_s5.bx = sym_sat(66'(round30(66'(r_s4.m0 + r_s4.m1))));
        n_s5.by = sym_sat(66'(round30(66'(r_s4.m3 - r_s4.m2))));
        n_s5.ee = 64'(r_s4.m4 + r_s4.m5);
    end

    // s6: vectors to both end points
    always_comb begin
        n_s6    = r_s5;
        n_s6.ux = sym_sat(66'(r_s5.bx - r_s5.p1x));
        n_s6.uy = sym_sat(66'(r_s5.by - r_s5.p1y));
        n_s6.qx = sym_sat(66'(r_s5.p2x - r_s5.bx));
        n_s6.qy = sym_sat(66'(r_s5.p2y - r_s5.by));
    end

    // s7: projection products
    always_comb begin
        n_s7    = r_s6;
        n_s7.m0 = 64'(r_s6.ux * r_s6.ex);
        n_s7.m1 = 64'(r_s6.uy * r_s6.ey);
        n_s7.m2 = 64'(r_s6.qx * r_s6.ex);
        n_s7.m3 = 64'(r_s6.qy * r_s6.ey);
    end

    // s8: projections and region of the segment
    always_comb begin
        n_s8    = r_s7;
        n_s8.s1 = 65'(r_s7.m0 + r_s7.m1);
        n_s8.s2 = 65'(r_s7.m2 + r_s7.m3);
        if (n_s8.s1 < 0 || r_s7.ee == '0) begin
            n_s8.sel = SEG_P1;
        end else if (n_s8.s2 < 0 || n_s8.s1 >= $signed({1'b0, r_s7.ee})) begin
            n_s8.sel = SEG_P2;
        end else begin
            n_s8.sel = SEG_MID;
        end
    end

    // segment fraction t = s1 / |e|^2 in Q0.30
    ccc_div_pipe #(
        .W     (64),
        .K     (FRAC_BITS),
        .LANES (1),
        .SW    (CTX_W)
    ) u_div_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld_a[7]),
        .i_num   (r_s8.s1[63:0]),
        .i_den   (r_s8.ee),
        .i_side  (r_s8),
        .o_vld   (w_dt_vld),
        .o_quo   (w_dt_quo),
        .o_side  (w_dt_side)
    );

    // s9: segment offset products
    always_comb begin
        n_s9    = t_ctx'(w_dt_side);
        n_s9.t  = w_dt_quo[0][FRAC_BITS-1:0];
        n_s9.m0 = 64'(n_s9.ex * $signed({2'b0, n_s9.t}));
        n_s9.m1 = 64'(n_s9.ey * $signed({2'b0, n_s9.t}));
    end

    // s10: nearest point on the segment
    always_comb begin
        n_s10 = r_s9;
        unique case (r_s9.sel)
            SEG_P1: begin
                n_s10.ax = r_s9.p1x;
                n_s10.ay = r_s9.p1y;
            end
            SEG_P2: begin
                n_s10.ax = r_s9.p2x;
                n_s10.ay = r_s9.p2y;
            end
            SEG_MID: begin
                n_s10.ax = sym_sat(66'(r_s9.p1x + round30(66'(r_s9.m0))));
                n_s10.ay = sym_sat(66'(r_s9.p1y + round30(66'(r_s9.m1))));
            end
            default: begin
                n_s10.ax = r_s9.p1x;
                n_s10.ay = r_s9.p1y;
            end
        endcase
    end

    // s11: offset from segment to circle center
    always_comb begin
        n_s11    = r_s10;
        n_s11.vx = sym_sat(66'(r_s10.bx - r_s10.ax));
        n_s11.vy = sym_sat(66'(r_s10.by - r_s10.ay));
    end

    // s12: squares of the offset
    always_comb begin
        n_s12    = r_s11;
        n_s12.m0 = 64'(r_s11.vx * r_s11.vx);
        n_s12.m1 = 64'(r_s11.vy * r_s11.vy);
    end

    // s13: squared length
    always_comb begin
        n_s13    = r_s12;
        n_s13.sq = 64'(r_s12.m0 + r_s12.m1);
    end

    // distance as integer square root
    ccc_sqrt_pipe #(
        .SW (CTX_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld_b[4]),
        .i_n     (r_s13.sq),
        .i_side  (r_s13),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // s14: magnitudes for the normal, separation and contact test
    always_comb begin
        n_s14      = t_ctx'(w_sq_side);
        n_s14.dlen = w_sq_root;
        n_s14.negx = n_s14.vx[31];
        n_s14.negy = n_s14.vy[31];
        n_s14.mvx  = n_s14.vx[31] ? 31'(-n_s14.vx) : n_s14.vx[30:0];
        n_s14.mvy  = n_s14.vy[31] ? 31'(-n_s14.vy) : n_s14.vy[30:0];
        n_s14.sep  = $signed({2'b0, w_sq_root}) - $signed({3'b0, n_s14.ra})
                   - $signed({3'b0, n_s14.rb});
        n_s14.hit  = n_s14.sep <= $signed({3'b0, r_spec});
    end

    // unit normal, both components against the same distance
    ccc_div_pipe #(
        .W     (DIST_W),
        .K     (FRAC_BITS),
        .LANES (2),
        .SW    (CTX_W)
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld_c),
        .i_num   ({{1'b0, r_s14.mvy}, {1'b0, r_s14.mvx}}),
        .i_den   (r_s14.dlen),
        .i_side  (r_s14),
        .o_vld   (w_dn_vld),
        .o_quo   (w_dn_quo),
        .o_side  (w_dn_side)
    );

    // s15: signed normal, zero for a zero-length offset
    always_comb begin
        logic signed [31:0] l_qx, l_qy;
        n_s15 = t_ctx'(w_dn_side);
        l_qx  = $signed({1'b0, w_dn_quo[0]});
        l_qy  = $signed({1'b0, w_dn_quo[1]});
        if (n_s15.dlen == '0) begin
            n_s15.nx = '0;
            n_s15.ny = '0;
        end else begin
            n_s15.nx = n_s15.negx ? -l_qx : l_qx;
            n_s15.ny = n_s15.negy ? -l_qy : l_qy;
        end
    end

    // s16: radius offsets and world normal products
    always_comb begin
        n_s16    = r_s15;
        n_s16.m0 = 64'($signed({1'b0, r_s15.ra}) * r_s15.nx);
        n_s16.m1 = 64'($signed({1'b0, r_s15.ra}) * r_s15.ny);
        n_s16.m2 = 64'($signed({1'b0, r_s15.rb}) * r_s15.nx);
        n_s16.m3 = 64'($signed({1'b0, r_s15.rb}) * r_s15.ny);
        n_s16.m4 = 64'(r_s15.ca * r_s15.nx);
        n_s16.m5 = 64'(r_s15.sa * r_s15.ny);
        n_s16.m6 = 64'(r_s15.sa * r_s15.nx);
        n_s16.m7 = 64'(r_s15.ca * r_s15.ny);
    end

    // s17: rounded offsets, world normal
    always_comb begin
        n_s17     = r_s16;
        n_s17.rax = round30(66'(r_s16.m0));
        n_s17.ray = round30(66'(r_s16.m1));
        n_s17.rbx = round30(66'(r_s16.m2));
        n_s17.rby = round30(66'(r_s16.m3));
        n_s17.nwx = sat32(66'(round30(66'(r_s16.m4 - r_s16.m5))));
        n_s17.nwy = sat32(66'(round30(66'(r_s16.m6 + r_s16.m7))));
    end

    // s18: surface points of both shapes
    always_comb begin
        n_s18     = r_s17;
        n_s18.cax = 37'(r_s17.ax + r_s17.rax);
        n_s18.cay = 37'(r_s17.ay + r_s17.ray);
        n_s18.cbx = 37'(r_s17.bx - r_s17.rbx);
        n_s18.cby = 37'(r_s17.by - r_s17.rby);
    end

    // s19: midpoint, floored
    always_comb begin
        n_s19    = r_s18;
        n_s19.mx = sym_sat(66'((r_s18.cax + r_s18.cbx) >>> 1));
        n_s19.my = sym_sat(66'((r_s18.cay + r_s18.cby) >>> 1));
    end

    // s20: midpoint rotation products
    always_comb begin
        n_s20    = r_s19;
        n_s20.m0 = 64'(r_s19.ca * r_s19.mx);
        n_s20.m1 = 64'(r_s19.sa * r_s19.my);
        n_s20.m2 = 64'(r_s19.sa * r_s19.mx);
        n_s20.m3 = 64'(r_s19.ca * r_s19.my);
    end

    // s21: anchor relative to the capsule body
    always_comb begin
        n_s21       = r_s20;
        n_s21.anx   = sat32(66'(round30(66'(r_s20.m0 - r_s20.m1))));
        n_s21.anc_y = sat32(66'(round30(66'(r_s20.m2 + r_s20.m3))));
    end

    // s22: result, all zero when out of reach
    always_comb begin
        n_out = '0;
        if (r_s21.hit) begin
            n_out.contact       = 1'b1;
            n_out.normal_x      = r_s21.nwx;
            n_out.normal_y      = r_s21.nwy;
            n_out.anchor_a_x    = r_s21.anx;
            n_out.anchor_a_y    = r_s21.anc_y;
            n_out.anchor_b_x    = sat32(66'(r_s21.anx + r_s21.pax - r_s21.pbx));
            n_out.anchor_b_y    = sat32(66'(r_s21.anc_y + r_s21.pay - r_s21.pby));
            n_out.world_point_x = sat32(66'(r_s21.pax + r_s21.anx));
            n_out.world_point_y = sat32(66'(r_s21.pay + r_s21.anc_y));
            n_out.separation    = sat32(66'(r_s21.sep));
        end
    end

    // valid bits per pipeline section
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= '0;
            r_vld_b <= '0;
            r_vld_c <= 1'b0;
            r_vld_d <= '0;
        end else begin
            r_vld_a <= {r_vld_a[6:0], w_accept};
            r_vld_b <= {r_vld_b[3:0], w_dt_vld};
            r_vld_c <= w_sq_vld;
            r_vld_d <= {r_vld_d[6:0], w_dn_vld};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_s3  <= n_s3;
        r_s4  <= n_s4;
        r_s5  <= n_s5;
        r_s6  <= n_s6;
        r_s7  <= n_s7;
        r_s8  <= n_s8;
        r_s9  <= n_s9;
        r_s10 <= n_s10;
        r_s11 <= n_s11;
        r_s12 <= n_s12;
        r_s13 <= n_s13;
        r_s14 <= n_s14;
        r_s15 <= n_s15;
        r_s16 <= n_s16;
        r_s17 <= n_s17;
        r_s18 <= n_s18;
        r_s19 <= n_s19;
        r_s20 <= n_s20;
        r_s21 <= n_s21;
        r_out <= n_out;
    end

    assign o_result_strobe = r_vld_d[7];
    assign o_result        = r_out;

endmodule

// File: sv/ccc_div_pipe.sv
module ccc_div_pipe #(
    parameter int W     = 64,
    parameter int K     = 30,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [LANES-1:0][W-1:0]     i_num,
    input  logic [W-1:0]                i_den,
    input  logic [SW-1:0]               i_side,
    output logic                        o_vld,
    output logic [LANES-1:0][K:0]       o_quo,
    output logic [SW-1:0]               o_side
);

    // one quotient bit per stage, divisor shared by all lanes
    logic [K:0]                  r_vld;
    logic [W-1:0]                r_den  [0:K];
    logic [SW-1:0]               r_side [0:K];
    logic [LANES-1:0][W:0]       r_rem  [0:K];
    logic [LANES-1:0][K:0]       r_quo  [0:K];
    logic [LANES-1:0][W:0]       n_rem  [0:K];
    logic [LANES-1:0][K:0]       n_quo  [0:K];
    logic [W-1:0]                n_den  [0:K];
    logic [SW-1:0]               n_side [0:K];

    // restoring step for every stage and lane
    always_comb begin
        logic [W:0] l_src;
        for (int g = 0; g <= K; g++) begin
            if (g == 0) begin
                n_den[g]  = i_den;
                n_side[g] = i_side;
                n_quo[g]  = '0;
            end else begin
                n_den[g]  = r_den[g-1];
                n_side[g] = r_side[g-1];
                n_quo[g]  = r_quo[g-1];
            end
            for (int l = 0; l < LANES; l++) begin
                if (g == 0) begin
                    l_src = {1'b0, i_num[l]};
                end else begin
                    l_src = {r_rem[g-1][l][W-1:0], 1'b0};
                end
                if (l_src >= {1'b0, n_den[g]}) begin
                    n_rem[g][l]      = l_src - {1'b0, n_den[g]};
                    n_quo[g][l][K-g] = 1'b1;
                end else begin
                    n_rem[g][l]      = l_src;
                    n_quo[g][l][K-g] = 1'b0;
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[K-1:0], i_vld};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_side <= n_side;
    end

    assign o_vld  = r_vld[K];
    assign o_quo  = r_quo[K];
    assign o_side = r_side[K];

endmodule

// File: sv/ccc_sqrt_pipe.sv
module ccc_sqrt_pipe #(
    parameter int SW = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [ccc_pkg::SQRT_IN_W-1:0] i_n,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_vld,
    output logic [ccc_pkg::SQRT_OUT_W-1:0] o_root,
    output logic [SW-1:0]                 o_side
);
    import ccc_pkg::*;

    // one result bit per stage, digit by digit
    logic [SQRT_STAGES-1:0] r_vld;
    logic [SQRT_IN_W-1:0]   r_op   [0:SQRT_STAGES-1];
    logic [SQRT_IN_W-1:0]   r_res  [0:SQRT_STAGES-1];
    logic [SW-1:0]          r_side [0:SQRT_STAGES-1];
    logic [SQRT_IN_W-1:0]   n_op   [0:SQRT_STAGES-1];
    logic [SQRT_IN_W-1:0]   n_res  [0:SQRT_STAGES-1];
    logic [SW-1:0]          n_side [0:SQRT_STAGES-1];

    always_comb begin
        logic [SQRT_IN_W-1:0] l_op;
        logic [SQRT_IN_W-1:0] l_res;
        logic [SQRT_IN_W-1:0] l_one;
        logic [SQRT_IN_W-1:0] l_try;
        for (int g = 0; g < SQRT_STAGES; g++) begin
            if (g == 0) begin
                l_op      = i_n;
                l_res     = '0;
                n_side[g] = i_side;
            end else begin
                l_op      = r_op[g-1];
                l_res     = r_res[g-1];
                n_side[g] = r_side[g-1];
            end
            l_one = SQRT_IN_W'(1) << (SQRT_IN_W - 2 - 2 * g);
            l_try = l_res + l_one;
            if (l_op >= l_try) begin
                n_op[g]  = l_op - l_try;
                n_res[g] = (l_res >> 1) + l_one;
            end else begin
                n_op[g]  = l_op;
                n_res[g] = l_res >> 1;
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SQRT_STAGES-2:0], i_vld};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_res  <= n_res;
        r_side <= n_side;
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_root = r_res[SQRT_STAGES-1][SQRT_OUT_W-1:0];
    assign o_side = r_side[SQRT_STAGES-1];

endmodule

// File: sv/ccc_checker.sv
module ccc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_strobe,
    input ccc_pkg::t_result  o_result
);
    import ccc_pkg::*;

    // every accepted transaction yields a result strobe after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_result_strobe)
        else $error("accepted transaction produced no result");

    // no result without a transaction accepted the latency before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching transaction");

    // a pair out of reach reports nothing but zeros
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_result.contact) |-> (o_result == '0))
        else $error("no-contact result carries nonzero fields");

endmodule

bind capsule_circle_contact_top ccc_checker u_ccc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_result        (o_result)
);

// File: sim/tb_top.sv
module tb_top;
    import ccc_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_item               i_item;
    logic                o_result_strobe;
    t_result             o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [SPEC_W-1:0]   i_cfg_data;

    // predictor copy of the register
    logic [SPEC_W-1:0]   spec_dist;
    t_result             contact_q[$];
    int                  n_fail;

    capsule_circle_contact_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // fixed-point helpers
    function automatic longint clamp_sym(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483647) return -64'sd2147483647;
        return x;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint rnd30(longint x);
        return (x + 64'sd536870912) >>> 30;
    endfunction

    function automatic void turn(longint c, longint s, bit inv, longint vx, longint vy,
                                 output longint ox, output longint oy);
        longint x, y;
        x = clamp_sym(vx);
        y = clamp_sym(vy);
        if (inv) s = -s;
        ox = rnd30(c * x - s * y);
        oy = rnd30(s * x + c * y);
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned op, res, one;
        op = n;
        res = 0;
        one = 64'h4000_0000_0000_0000;
        while (one > op) one >>= 2;
        while (one != 0) begin
            if (op >= res + one) begin
                op -= res + one;
                res = (res >> 1) + one;
            end else begin
                res >>= 1;
            end
            one >>= 2;
        end
        return res;
    endfunction

    function automatic longint hi32(logic [63:0] v);
        return longint'($signed(v[63:32]));
    endfunction

    function automatic longint lo32(logic [63:0] v);
        return longint'($signed(v[31:0]));
    endfunction

    // contact predictor
    function automatic t_result predict_contact(t_item it);
        t_result r;
        longint p1x, p1y, p2x, p2y, ra, rb, ccx, ccy, pax, pay, ca, sa, pbx, pby, cb, sb;
        longint wx, wy, bx, by, ax, ay, vx, vy, nx, ny, ex, ey, ux, uy, qx, qy, s1, s2;
        longint dlen, sep, cax, cay, cbx, cby, mx, my, gx, gy, nwx, nwy, anx, any_v;
        longint unsigned ee, sq, rem, t;
        r = '0;
        nx = 0;
        ny = 0;
        p1x = hi32(it.capsule_end_one);  p1y = lo32(it.capsule_end_one);
        p2x = hi32(it.capsule_end_two);  p2y = lo32(it.capsule_end_two);
        ra = longint'(it.capsule_radius);
        rb = longint'(it.circle_radius);
        ccx = hi32(it.circle_center);    ccy = lo32(it.circle_center);
        pax = hi32(it.pose_a_position);  pay = lo32(it.pose_a_position);
        ca = hi32(it.pose_a_rotation);   sa = lo32(it.pose_a_rotation);
        pbx = hi32(it.pose_b_position);  pby = lo32(it.pose_b_position);
        cb = hi32(it.pose_b_rotation);   sb = lo32(it.pose_b_rotation);

        // circle center into capsule frame
        turn(cb, sb, 1'b0, ccx, ccy, wx, wy);
        wx = clamp32(wx + pbx);
        wy = clamp32(wy + pby);
        turn(ca, sa, 1'b1, wx - pax, wy - pay, bx, by);
        bx = clamp_sym(bx);
        by = clamp_sym(by);

        // nearest point of the segment
        ex = clamp_sym(p2x - p1x); ey = clamp_sym(p2y - p1y);
        ux = clamp_sym(bx - p1x);  uy = clamp_sym(by - p1y);
        qx = clamp_sym(p2x - bx);  qy = clamp_sym(p2y - by);
        s1 = ux * ex + uy * ey;
        s2 = qx * ex + qy * ey;
        ee = longint'(ex * ex) + longint'(ey * ey);
        if (s1 < 0 || ee == 0) begin
            ax = p1x; ay = p1y;
        end else if (s2 < 0 || longint'(s1) >= ee) begin
            ax = p2x; ay = p2y;
        end else begin
            rem = s1;
            t = 0;
            for (int i = 0; i < 30; i++) begin
                rem <<= 1;
                t <<= 1;
                if (rem >= ee) begin
                    rem -= ee;
                    t |= 1;
                end
            end
            ax = clamp_sym(p1x + rnd30(ex * longint'(t)));
            ay = clamp_sym(p1y + rnd30(ey * longint'(t)));
        end

        vx = clamp_sym(bx - ax);
        vy = clamp_sym(by - ay);
        sq = longint'(vx * vx) + longint'(vy * vy);
        dlen = longint'(root64(sq));
        if (dlen != 0) begin
            nx = (vx * (64'sd1 << 30)) / dlen;
            ny = (vy * (64'sd1 << 30)) / dlen;
        end
        sep = dlen - ra - rb;
        if (sep > longint'(spec_dist)) return r;

        cax = ax + rnd30(ra * nx); cay = ay + rnd30(ra * ny);
        cbx = bx - rnd30(rb * nx); cby = by - rnd30(rb * ny);
        mx = (cax + cbx) >>> 1;
        my = (cay + cby) >>> 1;
        turn(ca, sa, 1'b0, nx, ny, nwx, nwy);
        turn(ca, sa, 1'b0, mx, my, anx, any_v);
        anx = clamp32(anx);
        any_v = clamp32(any_v);
        gx = clamp32(anx + pax - pbx);
        gy = clamp32(any_v + pay - pby);
        r.contact       = 1'b1;
        r.normal_x      = 32'(clamp32(nwx));
        r.normal_y      = 32'(clamp32(nwy));
        r.anchor_a_x    = 32'(anx);
        r.anchor_a_y    = 32'(any_v);
        r.anchor_b_x    = 32'(gx);
        r.anchor_b_y    = 32'(gy);
        r.world_point_x = 32'(clamp32(pax + anx));
        r.world_point_y = 32'(clamp32(pay + any_v));
        r.separation    = 32'(clamp32(sep));
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (contact_q.size() == 0) begin
                $error("result with no pending transaction");
                n_fail++;
            end else begin
                want = contact_q.pop_front();
                if (want.contact !== o_result.contact) begin
                    $error("contact exp %0d got %0d", want.contact, o_result.contact);
                    n_fail++;
                end
                if (want.normal_x !== o_result.normal_x) begin
                    $error("normal_x exp %0d got %0d", want.normal_x, o_result.normal_x);
                    n_fail++;
                end
                if (want.normal_y !== o_result.normal_y) begin
                    $error("normal_y exp %0d got %0d", want.normal_y, o_result.normal_y);
                    n_fail++;
                end
                if (want.anchor_a_x !== o_result.anchor_a_x) begin
                    $error("anchor_a_x exp %0d got %0d", want.anchor_a_x, o_result.anchor_a_x);
                    n_fail++;
                end
                if (want.anchor_a_y !== o_result.anchor_a_y) begin
                    $error("anchor_a_y exp %0d got %0d", want.anchor_a_y, o_result.anchor_a_y);
                    n_fail++;
                end
                if (want.anchor_b_x !== o_result.anchor_b_x) begin
                    $error("anchor_b_x exp %0d got %0d", want.anchor_b_x, o_result.anchor_b_x);
                    n_fail++;
                end
                if (want.anchor_b_y !== o_result.anchor_b_y) begin
                    $error("anchor_b_y exp %0d got %0d", want.anchor_b_y, o_result.anchor_b_y);
                    n_fail++;
                end
                if (want.world_point_x !== o_result.world_point_x) begin
                    $error("world_point_x exp %0d got %0d", want.world_point_x,
                           o_result.world_point_x);
                    n_fail++;
                end
                if (want.world_point_y !== o_result.world_point_y) begin
                    $error("world_point_y exp %0d got %0d", want.world_point_y,
                           o_result.world_point_y);
                    n_fail++;
                end
                if (want.separation !== o_result.separation) begin
                    $error("separation exp %0d got %0d", want.separation, o_result.separation);
                    n_fail++;
                end
            end
        end
    end

    // send one pair, with a random lead-in gap; start stays high back to back
    task automatic send_pair(t_item it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        contact_q.push_back(predict_contact(it));
    endtask

    // write the speculative distance while idle
    task automatic write_spec(logic [SPEC_W-1:0] v);
        start <= 1'b0;
        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        spec_dist = v;
    endtask

    function automatic logic [63:0] pack2(longint x, longint y);
        return {x[31:0], y[31:0]};
    endfunction

    // a plausible pair near the origin with a near-unit rotation
    function automatic t_item near_pair(int span);
        t_item it;
        real ang;
        longint c, s;
        ang = $urandom_range(0, 6283) / 1000.0;
        c = longint'($cos(ang) * 1073741824.0);
        s = longint'($sin(ang) * 1073741824.0);
        it.capsule_end_one = pack2($signed($urandom_range(0, 2 * span)) - span,
                                   $signed($urandom_range(0, 2 * span)) - span);
        it.capsule_end_two = $urandom_range(0, 9) == 0 ? it.capsule_end_one :
                             pack2($signed($urandom_range(0, 2 * span)) - span,
                                   $signed($urandom_range(0, 2 * span)) - span);
        it.capsule_radius  = 31'($urandom_range(0, span));
        it.circle_center   = pack2($signed($urandom_range(0, 2 * span)) - span,
                                   $signed($urandom_range(0, 2 * span)) - span);
        it.circle_radius   = 31'($urandom_range(0, span));
        it.pose_a_position = pack2($signed($urandom_range(0, 2 * span)) - span,
                                   $signed($urandom_range(0, 2 * span)) - span);
        it.pose_a_rotation = pack2(c, s);
        ang = $urandom_range(0, 6283) / 1000.0;
        c = longint'($cos(ang) * 1073741824.0);
        s = longint'($sin(ang) * 1073741824.0);
        it.pose_b_position = pack2($signed($urandom_range(0, 2 * span)) - span,
                                   $signed($urandom_range(0, 2 * span)) - span);
        it.pose_b_rotation = pack2(c, s);
        return it;
    endfunction

    function automatic t_item noise_pair();
        t_item it;
        it.capsule_end_one = {$urandom, $urandom};
        it.capsule_end_two = {$urandom, $urandom};
        it.capsule_radius  = 31'($urandom);
        it.circle_center   = {$urandom, $urandom};
        it.circle_radius   = 31'($urandom);
        it.pose_a_position = {$urandom, $urandom};
        it.pose_a_rotation = {$urandom, $urandom};
        it.pose_b_position = {$urandom, $urandom};
        it.pose_b_rotation = {$urandom, $urandom};
        return it;
    endfunction

    // extremes, degenerate capsule, zero offset, clamped ends
    task automatic test_directed();
        t_item it;
        it = '0;
        it.pose_a_rotation = pack2(64'sd1073741824, 0);
        it.pose_b_rotation = pack2(64'sd1073741824, 0);
        send_pair(it);                                   // zero offset, degenerate
        it.capsule_end_two = pack2(64'sd655360, 0);
        it.circle_center   = pack2(64'sd327680, 64'sd65536);
        it.capsule_radius  = 31'd32768;
        it.circle_radius   = 31'd65536;
        send_pair(it);                                   // interior point
        it.circle_center   = pack2(-64'sd131072, 64'sd1000);
        send_pair(it);                                   // before first end
        it.circle_center   = pack2(64'sd1310720, -64'sd1000);
        send_pair(it);                                   // past second end
        it.circle_center   = pack2(64'sd655360, 0);
        send_pair(it);                                   // on second end
        it.circle_center   = pack2(64'sd327680, 64'sd6553600);
        send_pair(it);                                   // no contact
        it.pose_a_rotation = pack2(0, 64'sd1073741824);
        it.pose_b_rotation = pack2(-64'sd1073741824, 0);
        it.circle_center   = pack2(64'sd327680, 64'sd65536);
        send_pair(it);                                   // quarter and half turns
        it.pose_a_rotation = {32'h7fffffff, 32'h80000000};
        send_pair(it);                                   // non-unit rotation
        it = '1;
        send_pair(it);
        it = '0;
        it.capsule_end_one = {32'h80000000, 32'h7fffffff};
        it.capsule_end_two = {32'h7fffffff, 32'h80000000};
        it.circle_center   = {32'h7fffffff, 32'h7fffffff};
        it.pose_a_position = {32'h80000000, 32'h80000000};
        it.pose_b_position = {32'h7fffffff, 32'h7fffffff};
        it.pose_a_rotation = {32'h7fffffff, 32'h7fffffff};
        it.pose_b_rotation = {32'h80000000, 32'h80000000};
        it.capsule_radius  = '1;
        it.circle_radius   = '1;
        send_pair(it);                                   // overflow everywhere
        it.capsule_radius  = '0;
        it.circle_radius   = '0;
        send_pair(it);
        for (int i = 0; i < 6; i++) send_pair(near_pair(400000));
    endtask

    // random pairs under one register setting
    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       send_pair(noise_pair());
                1, 2:    send_pair(near_pair(2000));
                default: send_pair(near_pair(300000));
            endcase
        end
    endtask

    // limit
    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        n_fail      = 0;
        spec_dist   = SPEC_RESET;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(100);
        write_spec('0);
        test_directed();
        test_random(100);
        write_spec('1);
        test_random(100);
        write_spec(31'd65536);
        test_random(100);
        write_spec(31'($urandom));
        test_random(100);

        start <= 1'b0;
        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/ccc_pkg.sv
sv/ccc_div_pipe.sv
sv/ccc_sqrt_pipe.sv
sv/capsule_circle_contact_top.sv
sv/ccc_checker.sv
sim/tb_top.sv
